// ===== hw/rtl/tmcom_pkg.sv =====
package tmcom_pkg;

    localparam int CoordBits = 12;
    localparam int MassShift = 16;
    localparam int MassBits  = 48;
    localparam int MomBits   = 64;
    localparam int DensBits  = 9;

    localparam logic [MassBits-1:0] MassMax = {MassBits{1'b1}};
    localparam logic signed [MomBits-1:0] MomMax = {1'b0, {(MomBits-1){1'b1}}};
    localparam logic signed [MomBits-1:0] MomMin = {1'b1, {(MomBits-1){1'b0}}};

    typedef struct packed {
        logic signed [11:0] vx;
        logic signed [11:0] vy;
        logic signed [11:0] vz;
        logic [8:0]         density;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [11:0] com_x;
        logic signed [11:0] com_y;
        logic signed [11:0] com_z;
        logic               no_mass;
        logic               saturated;
    } t_com;

endpackage

// ===== hw/rtl/tmcom_if.sv =====
interface tmcom_vtx_if;
    import tmcom_pkg::*;
    logic    valid;
    logic    ready;
    t_vertex data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmcom_com_if;
    import tmcom_pkg::*;
    logic valid;
    logic ready;
    t_com data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tet_mesh_center_of_mass_unit.sv =====
// Vertices 1-3 of a tetrahedron are stored as they are accepted; the fourth holds the
// input while the work runs through one shared 34x34 signed multiplier (accept, 6 cross
// products, 3 triple terms, 2 mass products, 2 moment products per axis).
// A last vertex adds setup, then a restoring divide per axis, before the result
// word is valid; input waits until that word is taken.
// No new vertex is accepted while a tetrahedron or a result is still in progress.
// i_rst_n synchronous active low: clears vertex slot, accumulators and flags.
module tet_mesh_center_of_mass_unit (
    input logic i_clk,
    input logic i_rst_n,
    tmcom_vtx_if.sink   i_vtx,
    tmcom_com_if.source o_com
);
    import tmcom_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_TRIP, S_MASS, S_MOM, S_DIVSET, S_DIV, S_AXIS, S_OUT
    } t_state;

    t_state r_state;
    logic signed [13:0] r_hv [3][3];
    logic [1:0]  r_slot;
    logic signed [MomBits-1:0] r_mom [3];
    logic [MassBits-1:0] r_total;
    logic        r_sat, r_clamp, r_last;
    logic [4:0]  r_step;
    logic signed [33:0] r_ma, r_mb;
    logic signed [67:0] r_prod;
    logic signed [13:0] r_a [3], r_b [3], r_c [3], r_s [3];
    logic signed [27:0] r_cr [3];
    logic signed [43:0] r_trip;
    logic [DensBits-1:0] r_dens;
    logic [MassBits+DensBits-1:0] r_vd;
    logic [MassBits-1:0] r_m;
    logic signed [MomBits+1:0] r_madd;
    logic [1:0]  r_axis;
    logic [6:0]  r_bit;
    logic [MomBits-1:0] r_rem, r_quo, r_num;
    logic [MassBits+1:0] r_div;
    logic        r_neg;
    logic signed [11:0] r_out [3];
    logic        r_valid, r_nomass;

    logic signed [13:0] w_v [3];
    logic [67:0] w_mul;
    logic [MomBits:0] w_sub;
    logic [43:0] w_vol;

    assign w_v[0] = 14'(signed'(i_vtx.data.vx));
    assign w_v[1] = 14'(signed'(i_vtx.data.vy));
    assign w_v[2] = 14'(signed'(i_vtx.data.vz));
    assign w_mul  = 68'(r_ma * r_mb);
    assign w_sub  = {r_rem, r_num[MomBits-1]} - {{(MomBits-MassBits-1){1'b0}}, r_div};
    assign w_vol  = r_trip[43] ? 44'(-r_trip) : 44'(r_trip);
    assign i_vtx.ready = (r_state == S_IDLE) && !r_valid;
    assign o_com.valid = r_valid;
    assign o_com.data  = '{r_out[0], r_out[1], r_out[2], r_nomass, r_sat | r_clamp};

    // mass * sum: mass split into low 24 / high 24 bits, two products per axis
    logic [MassBits+DensBits-1:0] w_mraw;
    assign w_mraw = r_vd >> MassShift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_slot <= '0; r_total <= '0; r_sat <= 1'b0;
            r_clamp <= 1'b0; r_valid <= 1'b0; r_step <= '0;
            for (int i = 0; i < 3; i++) begin
                r_mom[i] <= '0;
                for (int j = 0; j < 3; j++) r_hv[i][j] <= '0;
            end
        end else begin
            r_prod <= signed'(w_mul);
            if (r_valid && o_com.ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_vtx.valid && i_vtx.ready) begin
                    r_last <= i_vtx.data.last_vertex;
                    r_dens <= i_vtx.data.density;
                    if (r_slot == 2'd3) begin
                        for (int k = 0; k < 3; k++) begin
                            r_a[k] <= r_hv[1][k] - r_hv[0][k];
                            r_b[k] <= r_hv[2][k] - r_hv[0][k];
                            r_c[k] <= w_v[k] - r_hv[0][k];
                            r_s[k] <= r_hv[0][k] + r_hv[1][k] + r_hv[2][k] + w_v[k];
                        end
                        r_slot <= '0; r_step <= '0; r_state <= S_MUL;
                    end else begin
                        for (int k = 0; k < 3; k++) r_hv[r_slot][k] <= w_v[k];
                        r_slot <= r_slot + 2'd1;
                        if (i_vtx.data.last_vertex) r_state <= S_DIVSET;
                    end
                end
                S_MUL: begin
                    // steps 0..5 issue products; each result passes through r_ma/r_mb, then r_prod
                    case (r_step)
                        5'd0: begin r_ma <= 34'(r_a[1]); r_mb <= 34'(r_b[2]); end
                        5'd1: begin r_ma <= 34'(r_a[2]); r_mb <= 34'(r_b[1]); end
                        5'd2: begin r_ma <= 34'(r_a[2]); r_mb <= 34'(r_b[0]); end
                        5'd3: begin r_ma <= 34'(r_a[0]); r_mb <= 34'(r_b[2]); end
                        5'd4: begin r_ma <= 34'(r_a[0]); r_mb <= 34'(r_b[1]); end
                        default: begin r_ma <= 34'(r_a[1]); r_mb <= 34'(r_b[0]); end
                    endcase
                    case (r_step)
                        5'd2: r_cr[0] <= 28'(r_prod);
                        5'd3: r_cr[0] <= r_cr[0] - 28'(r_prod);
                        5'd4: r_cr[1] <= 28'(r_prod);
                        5'd5: r_cr[1] <= r_cr[1] - 28'(r_prod);
                        default: ;
                    endcase
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd5) begin r_step <= '0; r_state <= S_TRIP; end
                end
                S_TRIP: begin
                    case (r_step)
                        5'd0: begin
                            r_cr[2] <= 28'(r_prod);
                            r_ma <= 34'(r_cr[0]); r_mb <= 34'(r_c[0]);
                        end
                        5'd1: begin
                            r_cr[2] <= r_cr[2] - 28'(r_prod);
                            r_ma <= 34'(r_cr[1]); r_mb <= 34'(r_c[1]);
                        end
                        5'd2: begin
                            r_ma <= 34'(r_cr[2]); r_mb <= 34'(r_c[2]);
                            r_trip <= 44'(r_prod);
                        end
                        5'd3: r_trip <= r_trip + 44'(r_prod);
                        default: begin
                            r_trip <= r_trip + 44'(r_prod);
                        end
                    endcase
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd4) begin r_step <= '0; r_state <= S_MASS; end
                end
                S_MASS: begin
                    // vol6 < 2^40: low 24 / high 20 bits, each times the density
                    case (r_step)
                        5'd0: begin
                            r_ma <= 34'({1'b0, w_vol[23:0]});
                            r_mb <= 34'(r_dens);
                        end
                        5'd1: begin
                            r_ma <= 34'({1'b0, w_vol[43:24]});
                            r_mb <= 34'(r_dens);
                        end
                        5'd2: r_vd <= (MassBits+DensBits)'(unsigned'(r_prod));
                        5'd3: r_vd <= r_vd + ((MassBits+DensBits)'(unsigned'(r_prod)) << 24);
                        default: begin
                            if (w_mraw > (MassBits+DensBits)'(MassMax)) begin
                                r_m <= MassMax; r_sat <= 1'b1;
                            end else r_m <= MassBits'(w_mraw);
                        end
                    endcase
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd4) begin r_step <= '0; r_axis <= '0; r_state <= S_MOM; end
                end
                S_MOM: begin
                    // per axis: lo product, hi product, combine, accumulate
                    case (r_step)
                        5'd0: begin r_ma <= 34'({1'b0, r_m[23:0]}); r_mb <= 34'(r_s[r_axis]); end
                        5'd1: begin r_ma <= 34'({1'b0, r_m[47:24]}); r_mb <= 34'(r_s[r_axis]); end
                        5'd2: r_madd <= 66'(r_prod);
                        5'd3: r_madd <= r_madd + (66'(r_prod) <<< 24);
                        default: begin
                            if (r_madd + 66'(r_mom[r_axis]) > 66'(MomMax)) begin
                                r_mom[r_axis] <= MomMax; r_sat <= 1'b1;
                            end else if (r_madd + 66'(r_mom[r_axis]) < 66'(MomMin)) begin
                                r_mom[r_axis] <= MomMin; r_sat <= 1'b1;
                            end else r_mom[r_axis] <= MomBits'(r_madd + 66'(r_mom[r_axis]));
                        end
                    endcase
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd4) begin
                        r_step <= '0;
                        r_axis <= r_axis + 2'd1;
                        if (r_axis == 2'd2) begin
                            if ({1'b0, r_total} + {1'b0, r_m} > {1'b0, MassMax}) begin
                                r_total <= MassMax; r_sat <= 1'b1;
                            end else r_total <= r_total + r_m;
                            r_state <= r_last ? S_DIVSET : S_IDLE;
                        end
                    end
                end
                S_DIVSET: begin
                    r_axis <= '0;
                    r_nomass <= (r_total == '0);
                    r_div <= {r_total, 2'b00};
                    r_state <= S_AXIS;
                end
                S_AXIS: begin
                    r_neg <= r_mom[r_axis][MomBits-1];
                    r_num <= r_mom[r_axis][MomBits-1] ? MomBits'(-r_mom[r_axis])
                                                      : MomBits'(r_mom[r_axis]);
                    r_rem <= '0; r_quo <= '0; r_bit <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!w_sub[MomBits]) begin
                        r_rem <= w_sub[MomBits-1:0];
                        r_quo <= {r_quo[MomBits-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[MomBits-2:0], r_num[MomBits-1]};
                        r_quo <= {r_quo[MomBits-2:0], 1'b0};
                    end
                    r_num <= {r_num[MomBits-2:0], 1'b0};
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == 7'(MomBits-1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_nomass) r_out[r_axis] <= '0;
                    else if (!r_neg && r_quo > 64'd2047) begin
                        r_out[r_axis] <= 12'sd2047; r_clamp <= 1'b1;
                    end else if (r_neg && r_quo > 64'd2048) begin
                        r_out[r_axis] <= -12'sd2048; r_clamp <= 1'b1;
                    end else r_out[r_axis] <= r_neg ? 12'(-r_quo) : 12'(r_quo);
                    r_axis <= r_axis + 2'd1;
                    if (r_axis == 2'd2) begin
                        r_valid <= 1'b1; r_state <= S_IDLE;
                    end else r_state <= S_AXIS;
                end
                default: r_state <= S_IDLE;
            endcase
            // clear mesh state as the result is posted
            if (r_state == S_OUT && r_axis == 2'd2) begin
                r_slot <= '0; r_total <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_mom[i] <= '0;
                    for (int j = 0; j < 3; j++) r_hv[i][j] <= '0;
                end
            end
            if (r_valid && o_com.ready) begin r_sat <= 1'b0; r_clamp <= 1'b0; end
        end
    end

    a_rdy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_com.valid |-> !i_vtx.ready) else $error("accept with result pending");
    a_nomass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_com.valid && o_com.data.no_mass) |-> (o_com.data.com_x == '0))
        else $error("no_mass with nonzero output");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tmcom_pkg::*;

    localparam int HoldCycles  = 600;
    localparam int HoldAt      = 400;
    localparam int StallLimit  = 5000;
    localparam int TailCycles  = 300;
    localparam longint SMax    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMin    = 64'sh8000_0000_0000_0000;
    localparam longint MassCap = (64'sd1 <<< MassBits) - 1;

    typedef struct {
        t_vertex vtx;
        bit      drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    tmcom_vtx_if vtx_bus ();
    tmcom_com_if com_bus ();

    tet_mesh_center_of_mass_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_bus.sink),
        .o_com   (com_bus.source)
    );

    t_pending pending_words[$];
    t_com     expected_coms[$];
    int       accepted_cnt;
    int       error_cnt;
    int       hold_cnt;
    bit       hold_done;
    int       quiet_cycles;

    // mesh state of the predictor
    longint tet_held[3][3];
    int     tet_slot;
    longint mesh_moment[3];
    longint mesh_mass;
    bit     mesh_sat;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp_add(longint acc, longint add, inout bit sat);
        if (add > 0 && acc > SMax - add) begin
            sat = 1'b1;
            return SMax;
        end
        if (add < 0 && acc < SMin - add) begin
            sat = 1'b1;
            return SMin;
        end
        return acc + add;
    endfunction

    task automatic clear_mesh();
        tet_held    = '{default: '{default: 0}};
        tet_slot    = 0;
        mesh_moment = '{default: 0};
        mesh_mass   = 0;
        mesh_sat    = 1'b0;
    endtask

    task automatic predict_center(t_vertex v);
        longint p[3], a[3], b[3], c[3], s[3];
        longint cx, cy, cz, trip, m, dv, q;
        bit     clip;
        t_com   r;
        p[0] = longint'(v.vx);
        p[1] = longint'(v.vy);
        p[2] = longint'(v.vz);
        if (tet_slot == 3) begin
            for (int k = 0; k < 3; k++) begin
                a[k] = tet_held[1][k] - tet_held[0][k];
                b[k] = tet_held[2][k] - tet_held[0][k];
                c[k] = p[k] - tet_held[0][k];
                s[k] = tet_held[0][k] + tet_held[1][k] + tet_held[2][k] + p[k];
            end
            cx = a[1] * b[2] - a[2] * b[1];
            cy = a[2] * b[0] - a[0] * b[2];
            cz = a[0] * b[1] - a[1] * b[0];
            trip = cx * c[0] + cy * c[1] + cz * c[2];
            if (trip < 0) trip = -trip;
            m = (trip * longint'(v.density)) >>> MassShift;
            if (m > MassCap) begin
                m = MassCap;
                mesh_sat = 1'b1;
            end
            for (int k = 0; k < 3; k++)
                mesh_moment[k] = clamp_add(mesh_moment[k], m * s[k], mesh_sat);
            mesh_mass = mesh_mass + m;
            if (mesh_mass > MassCap) begin
                mesh_mass = MassCap;
                mesh_sat  = 1'b1;
            end
            tet_slot = 0;
        end else begin
            for (int k = 0; k < 3; k++) tet_held[tet_slot][k] = p[k];
            tet_slot++;
        end
        if (v.last_vertex) begin
            clip = 1'b0;
            r    = '0;
            if (mesh_mass == 0) begin
                r.no_mass = 1'b1;
            end else begin
                dv = mesh_mass * 4;
                for (int k = 0; k < 3; k++) begin
                    q = mesh_moment[k] / dv;
                    if (q > 2047) begin
                        q = 2047;
                        clip = 1'b1;
                    end else if (q < -2048) begin
                        q = -2048;
                        clip = 1'b1;
                    end
                    if (k == 0) r.com_x = q[11:0];
                    else if (k == 1) r.com_y = q[11:0];
                    else r.com_z = q[11:0];
                end
            end
            r.saturated = mesh_sat | clip;
            expected_coms.push_back(r);
            clear_mesh();
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_cnt++;
    endtask

    task automatic push_vertex(int x, int y, int z, int dens, bit last, bit drain = 0);
        t_pending p;
        p.vtx.vx          = 12'(x);
        p.vtx.vy          = 12'(y);
        p.vtx.vz          = 12'(z);
        p.vtx.density     = 9'(dens);
        p.vtx.last_vertex = last;
        p.drain           = drain;
        pending_words.push_back(p);
    endtask

    function automatic int rand_coord(bit narrow);
        if (narrow) return $urandom_range(64) - 32;
        return $urandom_range(4095) - 2048;
    endfunction

    function automatic int rand_density();
        case ($urandom_range(3))
            0: return $urandom_range(511);
            1: return 256;
            default: return $urandom_range(256);
        endcase
    endfunction

    // one mesh: ntets whole tetrahedra, then an optional partial tail
    task automatic push_mesh(int ntets, int tail, bit drain);
        bit narrow;
        int total;
        int n;
        narrow = ($urandom_range(3) == 0);
        total  = ntets * 4 + tail;
        if (total == 0) total = 1;
        n = 0;
        for (int i = 0; i < total; i++) begin
            push_vertex(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
                        rand_density(), i == total - 1, drain && i == 0);
            n++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        logic    nvalid;
        t_vertex ndata;
        int      idle_pct;
        nvalid = vtx_bus.valid;
        ndata  = vtx_bus.data;
        if (!i_rst_n) begin
            nvalid = 1'b0;
        end else begin
            if (vtx_bus.valid && vtx_bus.ready) begin
                predict_center(vtx_bus.data);
                accepted_cnt++;
                void'(pending_words.pop_front());
                nvalid = 1'b0;
            end
            if (!nvalid && pending_words.size() > 0) begin
                idle_pct = accepted_cnt < 400 ? 33 : (accepted_cnt < 800 ? 81 : 0);
                if (!(pending_words[0].drain && expected_coms.size() > 0) &&
                    $urandom_range(99) >= idle_pct) begin
                    nvalid = 1'b1;
                    ndata  = pending_words[0].vtx;
                end
            end
        end
        vtx_bus.valid <= nvalid;
        vtx_bus.data  <= ndata;
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_com want;
        int   idle_pct;
        if (i_rst_n && com_bus.valid && com_bus.ready) begin
            if (expected_coms.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_coms.pop_front();
                if (com_bus.data.com_x !== want.com_x)
                    report_mismatch("com_x", com_bus.data.com_x, want.com_x);
                if (com_bus.data.com_y !== want.com_y)
                    report_mismatch("com_y", com_bus.data.com_y, want.com_y);
                if (com_bus.data.com_z !== want.com_z)
                    report_mismatch("com_z", com_bus.data.com_z, want.com_z);
                if (com_bus.data.no_mass !== want.no_mass)
                    report_mismatch("no_mass", com_bus.data.no_mass, want.no_mass);
                if (com_bus.data.saturated !== want.saturated)
                    report_mismatch("saturated", com_bus.data.saturated, want.saturated);
            end
        end
        idle_pct = accepted_cnt < 400 ? 81 : (accepted_cnt < 800 ? 33 : 0);
        if (!hold_done && accepted_cnt >= HoldAt) begin
            hold_done = 1'b1;
            hold_cnt  = HoldCycles;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            com_bus.ready <= 1'b0;
        end else begin
            com_bus.ready <= i_rst_n && ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((vtx_bus.valid && vtx_bus.ready) || (com_bus.valid && com_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        accepted_cnt  = 0;
        error_cnt     = 0;
        hold_cnt      = 0;
        hold_done     = 1'b0;
        quiet_cycles  = 0;
        vtx_bus.valid = 1'b0;
        vtx_bus.data  = '0;
        com_bus.ready = 1'b0;
        clear_mesh();
        i_rst_n = 1'b0;

        // empty mesh: lone last vertex gives no mass
        push_vertex(5, -7, 9, 256, 1);
        // corner extremes, full-range volume
        push_vertex(-2048, -2048, -2048, 256, 0);
        push_vertex(2047, -2048, -2048, 256, 0);
        push_vertex(-2048, 2047, -2048, 256, 0);
        push_vertex(-2048, -2048, 2047, 256, 1);
        // zero density
        push_vertex(0, 0, 0, 511, 0);
        push_vertex(100, 0, 0, 511, 0);
        push_vertex(0, 100, 0, 511, 0);
        push_vertex(0, 0, 100, 0, 1);
        // coplanar tetrahedron, zero volume
        push_vertex(1, 1, 0, 256, 0);
        push_vertex(50, 3, 0, 256, 0);
        push_vertex(-20, 40, 0, 256, 0);
        push_vertex(7, -9, 0, 256, 1);
        // max density, then partial tail dropped
        push_vertex(2047, 2047, 2047, 0, 0);
        push_vertex(-2048, 2047, 2047, 0, 0);
        push_vertex(2047, -2048, 2047, 0, 0);
        push_vertex(2047, 2047, -2048, 511, 0);
        push_vertex(300, 300, 300, 0, 0);
        push_vertex(-300, 300, 300, 0, 1);
        // two tetrahedra on the negative side
        push_vertex(-2000, -1000, -1500, 0, 0);
        push_vertex(-100, -1000, -1500, 0, 0);
        push_vertex(-2000, -50, -1500, 0, 0);
        push_vertex(-2000, -1000, -10, 300, 0);
        push_vertex(-1, -2, -3, 0, 0);
        push_vertex(-1800, -3, -4, 0, 0);
        push_vertex(-5, -1700, -6, 0, 0);
        push_vertex(-7, -8, -1900, 200, 1);

        while (pending_words.size() < 1150) begin
            if ($urandom_range(9) == 0)
                push_mesh($urandom_range(2), $urandom_range(3), 0);
            else
                push_mesh($urandom_range(1, 5), ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0,
                          pending_words.size() > 700 && pending_words.size() < 720);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_words.size() == 0 && expected_coms.size() == 0);
        repeat (TailCycles) @(posedge i_clk);
        if (error_cnt == 0 && expected_coms.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
